FILE: rtl/cfdmc_pkg.sv
// shared types and constants of the CAN-fed dashboard mode controller
package cfdmc_pkg;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGO_TICKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] LOGO_TICKS_RST   = 16'd350;
  localparam logic [CFG_DATA_W-1:0] LINK_TIMEOUT_RST = 16'd50;

  // identifier matching
  localparam logic [24:0] EXT_ID_INV1 = 25'h118ff71;
  localparam logic [24:0] EXT_ID_INV2 = 25'h118ff72;
  localparam logic [24:0] EXT_ID_INV3 = 25'h119ff71;
  localparam logic [24:0] EXT_ID_INV4 = 25'h119ff72;
  localparam logic [24:0] EXT_ID_INV5 = 25'h11aff71;
  localparam logic [24:0] EXT_ID_INV6 = 25'h11aff72;
  localparam logic [28:0] STD_ID_BATT_A = 29'h6B1;
  localparam logic [28:0] STD_ID_BATT_B = 29'h6B0;
  localparam logic [28:0] STD_ID_STATUS = 29'h7A4;

  // item kind
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

  typedef enum logic [3:0] {
    CLS_NONE     = 4'd0,
    CLS_INV1     = 4'd1,
    CLS_INV2     = 4'd2,
    CLS_INV3     = 4'd3,
    CLS_INV4     = 4'd4,
    CLS_INV5     = 4'd5,
    CLS_INV6     = 4'd6,
    CLS_BATT_A   = 4'd7,
    CLS_BATT_B   = 4'd8,
    CLS_STATUS   = 4'd9
  } cls_t;

  typedef enum logic [2:0] {
    SCR_NONE     = 3'd0,
    SCR_LOGO     = 3'd1,
    SCR_PREDRIVE = 3'd2,
    SCR_DRIVE    = 3'd3,
    SCR_DIAG     = 3'd4
  } scr_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_TEAR  = 2'd1,
    ACT_BUILD = 2'd2
  } act_t;

  // request as it arrives
  typedef struct packed {
    logic        func;
    logic        id_extended;
    logic [28:0] frame_id;
    logic [63:0] frame_payload;
  } in_item_t;

  // result as it leaves
  typedef struct packed {
    logic [1:0] screen_action;
    logic [2:0] action_screen;
    logic       refresh;
    logic [2:0] shown_screen;
    logic       link_ok;
    logic [7:0] fault_code;
    logic [3:0] frame_class;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_frame;
    cls_t       cls;
    logic [7:0] cur_limit;
    logic [4:0] status_bits;
    logic [7:0] fault;
  } cmd_t;

endpackage

FILE: rtl/can_fed_dashboard_mode_control_top.sv
// top level of the CAN-fed dashboard mode controller
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  input   | in_push, in_full, in_item      | one tick or CAN frame request
//  result  | out_pop, out_empty, out_item   | one result per request
//  config  | cfg_we, cfg_index, cfg_wdata   | register write, no wait
//
// one request per cycle sustained while results are popped; each request is
// classified into the command queue, then executed into the result queue.
// the back end executes one request per cycle when a command waits and
// the result queue has room. reset is synchronous and active low.
// a stalled result side fills the result queue, then the command queue,
// and only then raises in_full.
module can_fed_dashboard_mode_control_top #(
  parameter int unsigned REFRESH_TICKS = 20,
  parameter int unsigned CMD_DEPTH     = 2,
  parameter int unsigned RES_DEPTH     = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  cfdmc_pkg::in_item_t               in_item,
  output logic                              out_empty,
  input  logic                              out_pop,
  output cfdmc_pkg::out_item_t              out_item,
  input  logic                              cfg_we,
  input  logic [cfdmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfdmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfdmc_pkg::*;

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  logic      cmd_empty;
  logic      res_full;
  logic      take;
  out_item_t back_result;

  // classify
  cfdmc_front u_front (
    .in_item (in_item),
    .cmd     (front_cmd)
  );

  // command queue between front and back
  cfdmc_queue #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_cmd),
    .full  (in_full),
    .pop   (take),
    .rdata (head_cmd),
    .empty (cmd_empty)
  );

  // execute when a command waits and a result slot is free
  assign take = !cmd_empty && !res_full;

  cfdmc_back #(
    .REFRESH_TICKS (REFRESH_TICKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (head_cmd),
    .take      (take),
    .result    (back_result)
  );

  // result queue
  cfdmc_queue #(
    .W     ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (back_result),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

FILE: rtl/cfdmc_queue.sv
// small first-in first-out queue of registers
module cfdmc_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/cfdmc_front.sv
// front end: classifies incoming ticks and frames by identifier
module cfdmc_front (
  input  cfdmc_pkg::in_item_t in_item,
  output cfdmc_pkg::cmd_t     cmd
);
  import cfdmc_pkg::*;

  cls_t cls;

  // identifier lookup, extended ids masked to 25 bits
  always_comb begin
    cls = CLS_NONE;
    if (in_item.func == FUNC_FRAME) begin
      if (in_item.id_extended) begin
        case (in_item.frame_id[24:0])
          EXT_ID_INV1: cls = CLS_INV1;
          EXT_ID_INV2: cls = CLS_INV2;
          EXT_ID_INV3: cls = CLS_INV3;
          EXT_ID_INV4: cls = CLS_INV4;
          EXT_ID_INV5: cls = CLS_INV5;
          EXT_ID_INV6: cls = CLS_INV6;
          default:     cls = CLS_NONE;
        endcase
      end else begin
        case (in_item.frame_id)
          STD_ID_BATT_A: cls = CLS_BATT_A;
          STD_ID_BATT_B: cls = CLS_BATT_B;
          STD_ID_STATUS: cls = CLS_STATUS;
          default:       cls = CLS_NONE;
        endcase
      end
    end
  end

  // keep only the payload bytes the back end latches
  always_comb begin
    cmd.is_frame    = (in_item.func == FUNC_FRAME);
    cmd.cls         = cls;
    cmd.cur_limit   = in_item.frame_payload[39:32];
    cmd.status_bits = in_item.frame_payload[52:48];
    cmd.fault       = in_item.frame_payload[63:56];
  end

endmodule

FILE: rtl/cfdmc_back.sv
// back end: vehicle status, screen sequencing, refresh and link health
module cfdmc_back #(
  parameter int unsigned REFRESH_TICKS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [cfdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfdmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  cfdmc_pkg::cmd_t                      cmd,
  input  logic                                 take,
  output cfdmc_pkg::out_item_t                 result
);
  import cfdmc_pkg::*;

  localparam int unsigned PH_W = (REFRESH_TICKS > 1) ? $clog2(REFRESH_TICKS) : 1;

  logic [15:0]     logo_ticks_r;
  logic [15:0]     link_timeout_r;
  logic [31:0]     tick_count_r, tick_count_nxt;
  logic [31:0]     last_status_r, last_status_nxt;
  logic [PH_W-1:0] phase_r, phase_nxt;
  logic [7:0]      fault_r, fault_nxt;
  logic            rtd_r, rtd_nxt;
  logic            rtd_switch_r, rtd_switch_nxt;
  logic            link_alive_r, link_alive_nxt;
  logic [2:0]      unit_active_r, unit_active_nxt;
  logic [7:0]      cur_limit_r, cur_limit_nxt;
  scr_t            screen_r, screen_nxt;
  logic            build_pend_r, build_pend_nxt;

  scr_t            cmd_scr;
  act_t            action;
  scr_t            act_scr;
  logic            refresh;
  logic [31:0]     link_age;

  // commanded screen for a tick
  always_comb begin
    if (tick_count_r < {16'd0, logo_ticks_r}) begin
      cmd_scr = SCR_LOGO;
    end else if ((fault_r != 8'd0) || !link_alive_r) begin
      cmd_scr = SCR_DIAG;
    end else if (rtd_r) begin
      cmd_scr = SCR_DRIVE;
    end else begin
      cmd_scr = SCR_PREDRIVE;
    end
  end

  // state update for one request
  always_comb begin
    tick_count_nxt  = tick_count_r;
    last_status_nxt = last_status_r;
    phase_nxt       = phase_r;
    fault_nxt       = fault_r;
    rtd_nxt         = rtd_r;
    rtd_switch_nxt  = rtd_switch_r;
    link_alive_nxt  = link_alive_r;
    unit_active_nxt = unit_active_r;
    cur_limit_nxt   = cur_limit_r;
    screen_nxt      = screen_r;
    build_pend_nxt  = build_pend_r;
    action          = ACT_NONE;
    act_scr         = SCR_NONE;
    refresh         = 1'b0;
    link_age        = 32'd0;
    if (cmd.is_frame) begin
      if (cmd.cls == CLS_STATUS) begin
        cur_limit_nxt   = cmd.cur_limit;
        rtd_switch_nxt  = cmd.status_bits[4];
        rtd_nxt         = cmd.status_bits[3];
        unit_active_nxt = cmd.status_bits[2:0];
        last_status_nxt = tick_count_r;
        fault_nxt       = cmd.fault;
      end
    end else begin
      // tear down now, build on the next tick
      if (build_pend_r) begin
        build_pend_nxt = 1'b0;
        action         = ACT_BUILD;
        act_scr        = cmd_scr;
      end else if (cmd_scr != screen_r) begin
        if (screen_r != SCR_NONE) begin
          action  = ACT_TEAR;
          act_scr = screen_r;
        end
        build_pend_nxt = 1'b1;
        screen_nxt     = cmd_scr;
      end
      refresh = (phase_r == '0) && !build_pend_nxt;
      // phase tracks tick_count modulo REFRESH_TICKS, restarting on wrap
      if ((tick_count_r == 32'hFFFF_FFFF) || (phase_r == PH_W'(REFRESH_TICKS - 1))) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
      tick_count_nxt = tick_count_r + 32'd1;
      link_age       = tick_count_nxt - last_status_r;
      link_alive_nxt = (link_age <= {16'd0, link_timeout_r});
    end
  end

  // result fields after this request
  always_comb begin
    result.screen_action = action;
    result.action_screen = act_scr;
    result.refresh       = refresh;
    result.shown_screen  = screen_nxt;
    result.link_ok       = link_alive_nxt;
    result.fault_code    = fault_nxt;
    result.frame_class   = cmd.cls;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      logo_ticks_r   <= LOGO_TICKS_RST;
      link_timeout_r <= LINK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOGO_TICKS:   logo_ticks_r   <= cfg_wdata;
        CFG_LINK_TIMEOUT: link_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= '0;
      last_status_r <= '0;
      phase_r       <= '0;
      fault_r       <= '0;
      rtd_r         <= 1'b0;
      rtd_switch_r  <= 1'b0;
      link_alive_r  <= 1'b0;
      unit_active_r <= '0;
      cur_limit_r   <= '0;
      screen_r      <= SCR_NONE;
      build_pend_r  <= 1'b0;
    end else if (take) begin
      tick_count_r  <= tick_count_nxt;
      last_status_r <= last_status_nxt;
      phase_r       <= phase_nxt;
      fault_r       <= fault_nxt;
      rtd_r         <= rtd_nxt;
      rtd_switch_r  <= rtd_switch_nxt;
      link_alive_r  <= link_alive_nxt;
      unit_active_r <= unit_active_nxt;
      cur_limit_r   <= cur_limit_nxt;
      screen_r      <= screen_nxt;
      build_pend_r  <= build_pend_nxt;
    end
  end

  // a pending build always has a screen to build onto
  a_pend_has_screen: assert property (@(posedge clk) disable iff (!rst_n)
    build_pend_r |-> (screen_r != SCR_NONE))
    else $error("build pending with no screen");

  // a tear-down always names the screen torn down
  a_tear_named: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (result.screen_action == ACT_TEAR)) |-> (result.action_screen != SCR_NONE))
    else $error("tear-down without a screen");

  // a tick with a pending build consumes it
  a_build_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !cmd.is_frame && build_pend_r) |=> !build_pend_r)
    else $error("pending build not cleared");

  // frames never act on the screen nor refresh it
  a_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.is_frame) |-> ((result.screen_action == ACT_NONE) && !result.refresh))
    else $error("frame request touched the screen");

  // the refresh phase stays in range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_W'(REFRESH_TICKS - 1))
    else $error("refresh phase out of range");

endmodule
